// ----- rtl/sdq_pkg.sv -----
// shared constants and types for the scene depth quantile block
package sdq_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int DEPTH_W    = 32;
  localparam int COEF_W     = 18;
  localparam int QDIV_W     = 8;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COEF_W + DEPTH_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHR_W      = SUM_W - FRAC_W;
  localparam int SAT_W      = SHR_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QDIV  = 3'd4;

  typedef logic signed [DEPTH_W-1:0] depth_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    logic             ins_en;
    logic             shift_en;
    depth_t           depth;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   has_point;
    logic   last_slot;
    depth_t depth;
  } proj_res_t;

endpackage

// ----- rtl/sdq_ifs.sv -----
// valid/ready channel interfaces for point slots, results and register writes
interface sdq_in_if;
  import sdq_pkg::*;
  logic   valid;
  logic   ready;
  logic   has_point;
  depth_t point_x;
  depth_t point_y;
  depth_t point_z;
  logic   last_slot;
  modport source (output valid, has_point, point_x, point_y, point_z, last_slot,
                  input ready);
  modport sink (input valid, has_point, point_x, point_y, point_z, last_slot,
                output ready);
endinterface

interface sdq_out_if;
  import sdq_pkg::*;
  logic   valid;
  logic   ready;
  depth_t depth_quantile;
  logic   no_points;
  logic   overflowed;
  modport source (output valid, depth_quantile, no_points, overflowed, input ready);
  modport sink (input valid, depth_quantile, no_points, overflowed, output ready);
endinterface

interface sdq_cfg_if;
  import sdq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sdq_proj.sv -----
// three stage projection of a world point onto the camera depth axis
module sdq_proj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                has_point,
  input  sdq_pkg::depth_t     point_x,
  input  sdq_pkg::depth_t     point_y,
  input  sdq_pkg::depth_t     point_z,
  input  logic                last_slot,
  input  sdq_pkg::coef_t      rot_x,
  input  sdq_pkg::coef_t      rot_y,
  input  sdq_pkg::coef_t      rot_z,
  input  sdq_pkg::depth_t     trans_z,
  output sdq_pkg::proj_res_t  res
);
  import sdq_pkg::*;

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  logic                     s1_has_r, s2_has_r, s3_has_r;
  logic                     s1_last_r, s2_last_r, s3_last_r;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SHR_W-1:0]  shr_r;
  logic signed [SAT_W-1:0]  wide;
  logic [SAT_W-DEPTH_W:0]   hi;
  depth_t                   sat;
  depth_t                   depth_r;

  assign sum  = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r);
  assign wide = SAT_W'(shr_r) + SAT_W'(trans_z);
  assign hi   = wide[SAT_W-1:DEPTH_W-1];

  always_comb begin
    sat = wide[DEPTH_W-1:0];
    if (hi != '0 && hi != '1) begin
      sat = wide[SAT_W-1] ? {1'b1, {(DEPTH_W-1){1'b0}}} : {1'b0, {(DEPTH_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= PROD_W'(rot_x) * PROD_W'(point_x);
    py_r    <= PROD_W'(rot_y) * PROD_W'(point_y);
    pz_r    <= PROD_W'(rot_z) * PROD_W'(point_z);
    shr_r   <= sum[SUM_W-1:FRAC_W];
    depth_r <= sat;
    s1_has_r  <= has_point;
    s1_last_r <= last_slot;
    s2_has_r  <= s1_has_r;
    s2_last_r <= s1_last_r;
    s3_has_r  <= s2_has_r;
    s3_last_r <= s2_last_r;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign res.valid     = s3_valid_r;
  assign res.has_point = s3_has_r;
  assign res.last_slot = s3_last_r;
  assign res.depth     = depth_r;

endmodule

// ----- rtl/sdq_cell.sv -----
// one cell of the sorted insertion chain
module sdq_cell (
  input  logic                       clk,
  input  sdq_pkg::cell_ctrl_t        ctrl,
  input  logic [sdq_pkg::IDX_W-1:0]  cell_idx,
  input  sdq_pkg::depth_t            left_val,
  input  logic                       left_gt,
  input  sdq_pkg::depth_t            right_val,
  output sdq_pkg::depth_t            val,
  output logic                       gt
);
  import sdq_pkg::*;

  depth_t val_r;
  depth_t val_nxt;

  // empty cells count as larger than any depth
  assign gt  = (CNT_W'(cell_idx) >= ctrl.count) || (val_r > ctrl.depth);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift_en) begin
      val_nxt = right_val;
    end else if (ctrl.ins_en && gt) begin
      val_nxt = left_gt ? left_val : ctrl.depth;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/scene_depth_quantile_core.sv -----
// top level: projection, sorted cell chain and quantile readout
// accepts one point slot per cycle within a frame
// result is the stored depth at sorted index (n-1)/q, n = stored points; no_points if none
// the readout walks the cell chain one position per cycle toward cell 0
// no slot is taken from the last slot of a frame until its result is registered
// rst_n is synchronous, active low; clears control and registers, not the chain
module scene_depth_quantile_core (
  input  logic          clk,
  input  logic          rst_n,
  sdq_in_if.sink        in_ch,
  sdq_out_if.source     out_ch,
  sdq_cfg_if.sink       cfg_ch
);
  import sdq_pkg::*;

  typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_SCAN, ST_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  depth_t              out_depth_r, out_depth_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  coef_t               rot_x_r, rot_y_r, rot_z_r;
  depth_t              trans_r;
  logic [QDIV_W-1:0]   qdiv_r;
  logic [QDIV_W-1:0]   q_eff;
  logic [CNT_W:0]      acc_step;
  logic                advance;

  logic                in_accept;
  proj_res_t           proj;
  cell_ctrl_t          ctrl;
  depth_t              cell_val [MAX_POINTS];
  logic                cell_gt  [MAX_POINTS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= COEF_W'(65536);
      trans_r <= '0;
      qdiv_r  <= QDIV_W'(2);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROT_X: rot_x_r <= cfg_ch.data[COEF_W-1:0];
        REG_ROT_Y: rot_y_r <= cfg_ch.data[COEF_W-1:0];
        REG_ROT_Z: rot_z_r <= cfg_ch.data[COEF_W-1:0];
        REG_TRANS: trans_r <= cfg_ch.data[DEPTH_W-1:0];
        REG_QDIV:  qdiv_r  <= cfg_ch.data[QDIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_RUN);
  assign in_accept   = in_ch.valid && in_ch.ready;

  sdq_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .has_point (in_ch.has_point),
    .point_x   (in_ch.point_x),
    .point_y   (in_ch.point_y),
    .point_z   (in_ch.point_z),
    .last_slot (in_ch.last_slot),
    .rot_x     (rot_x_r),
    .rot_y     (rot_y_r),
    .rot_z     (rot_z_r),
    .trans_z   (trans_r),
    .res       (proj)
  );

  assign q_eff    = (qdiv_r == '0) ? QDIV_W'(1) : qdiv_r;
  assign acc_step = (CNT_W+1)'(acc_r) + (CNT_W+1)'(q_eff);
  assign advance  = acc_step < (CNT_W+1)'(count_r);

  assign ctrl.ins_en   = proj.valid && proj.has_point && (count_r < CNT_W'(MAX_POINTS));
  assign ctrl.shift_en = (state_r == ST_SCAN) && (count_r != '0) && advance;
  assign ctrl.depth    = proj.depth;
  assign ctrl.count    = count_r;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_chain
    depth_t left_val;
    logic   left_gt;
    depth_t right_val;
    if (g == 0) begin : g_first
      assign left_val = proj.depth;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[g-1];
      assign left_gt  = cell_gt[g-1];
    end
    if (g == MAX_POINTS - 1) begin : g_end
      assign right_val = cell_val[g];
    end else begin : g_mid
      assign right_val = cell_val[g+1];
    end
    sdq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(g)),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (cell_val[g]),
      .gt        (cell_gt[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_depth_nxt = out_depth_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (proj.valid && proj.has_point) begin
      if (ctrl.ins_en) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_RUN: begin
        if (in_accept && in_ch.last_slot) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (proj.valid && proj.last_slot) begin
          state_nxt = ST_SCAN;
          acc_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (ctrl.shift_en) begin
          acc_nxt = acc_step[CNT_W-1:0];
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = (count_r == '0);
          out_depth_nxt = (count_r == '0) ? '0 : cell_val[0];
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    out_depth_r <= out_depth_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.depth_quantile = out_depth_r;
  assign out_ch.no_points      = out_empty_r;
  assign out_ch.overflowed     = out_ovf_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(MAX_POINTS))
    else $error("overflow flagged with free cells");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && count_r != '0) |-> acc_r < count_r)
    else $error("readout index past stored points");

  a_no_insert_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DONE) |-> !proj.valid && !in_ch.ready)
    else $error("slot in flight during readout");
`endif

endmodule

// ----- bench/tb_scene_depth_quantile_core.sv -----
// self-checking testbench for scene_depth_quantile_core: directed and random point frames
`timescale 1ns / 1ps

module tb_scene_depth_quantile_core;
  import sdq_pkg::*;

  localparam depth_t DEPTH_MAX = 32'sh7FFF_FFFF;
  localparam depth_t DEPTH_MIN = 32'sh8000_0000;
  localparam int     N_DIR     = 19;

  typedef struct {
    logic   has;
    depth_t x;
    depth_t y;
    depth_t z;
    logic   last;
  } slot_t;

  typedef struct {
    depth_t depth;
    logic   none;
    logic   ovf;
  } quant_res_t;

  typedef struct {
    slot_t      slot;
    logic       typed;
    quant_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sdq_in_if  in_ch();
  sdq_out_if out_ch();
  sdq_cfg_if cfg_ch();

  scene_depth_quantile_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // pose and divisor as the block should hold them
  coef_t             cf_rx   = 18'sd0;
  coef_t             cf_ry   = 18'sd0;
  coef_t             cf_rz   = 18'sd65536;
  depth_t            cf_tz   = 32'sd0;
  logic [QDIV_W-1:0] cf_qdiv = 8'd2;

  depth_t     depth_sorted[$];
  logic       frame_ovf = 1'b0;
  quant_res_t quant_expq[$];

  int         bad_count  = 0;
  int         sent_items = 0;
  int         gap_pct    = 0;
  int         stall_left = 0;
  logic       typed_now  = 1'b0;
  quant_res_t typed_res;

  dir_row_t dir_rows [N_DIR] = '{
    '{'{1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0}, 1'b0,
      '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b0, DEPTH_MIN, DEPTH_MAX, DEPTH_MIN, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{1'b1, DEPTH_MIN, DEPTH_MAX, DEPTH_MAX, 1'b1}, 1'b1, '{DEPTH_MAX, 1'b0, 1'b0}},
    '{'{1'b1, DEPTH_MAX, DEPTH_MIN, DEPTH_MIN, 1'b1}, 1'b1, '{DEPTH_MIN, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd327680, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0}, 1'b0,
      '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd196608, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd196608, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, -32'sd458752, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd6553600, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd6553600, 1'b1}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd12345, -32'sd9, 32'sh0001_8000, 1'b1}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd2621440, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd1966080, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd1310720, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd655360, 1'b0}, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{'{1'b1, 32'sd0, 32'sd0, 32'sd0, 1'b1}, 1'b0, '{32'sd0, 1'b0, 1'b0}}
  };

  function automatic depth_t depth_of(depth_t px, depth_t py, depth_t pz);
    longint acc;
    acc = longint'(cf_rx) * longint'(px) + longint'(cf_ry) * longint'(py)
        + longint'(cf_rz) * longint'(pz);
    acc = (acc >>> FRAC_W) + longint'(cf_tz);
    if (acc > longint'(DEPTH_MAX)) return DEPTH_MAX;
    if (acc < longint'(DEPTH_MIN)) return DEPTH_MIN;
    return acc[DEPTH_W-1:0];
  endfunction

  // equal depths go after the ones already held
  function automatic void place_depth(depth_t d);
    int pos;
    if (depth_sorted.size() >= MAX_POINTS) begin
      frame_ovf = 1'b1;
      return;
    end
    pos = depth_sorted.size();
    while (pos > 0 && depth_sorted[pos-1] > d) pos--;
    depth_sorted.insert(pos, d);
  endfunction

  function automatic quant_res_t frame_quantile();
    quant_res_t r;
    int         n;
    int         q;
    n = depth_sorted.size();
    q = (cf_qdiv == '0) ? 1 : int'(cf_qdiv);
    r.ovf = frame_ovf;
    if (n == 0) begin
      r.depth = 32'sd0;
      r.none  = 1'b1;
    end else begin
      r.depth = depth_sorted[(n - 1) / q];
      r.none  = 1'b0;
    end
    return r;
  endfunction

  function automatic depth_t rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return (int'($urandom_range(16)) - 8) * 65536;
      2: begin
        case ($urandom_range(3))
          0: return DEPTH_MIN;
          1: return DEPTH_MAX;
          2: return 32'sd0;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      default: return int'($urandom_range(600)) - 300;
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(3))
      0: return -18'sd65536;
      1: return 18'sd65536;
      default: return COEF_W'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  always @(posedge clk) begin
    quant_res_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ROT_X: cf_rx = cfg_ch.data[COEF_W-1:0];
          REG_ROT_Y: cf_ry = cfg_ch.data[COEF_W-1:0];
          REG_ROT_Z: cf_rz = cfg_ch.data[COEF_W-1:0];
          REG_TRANS: cf_tz = cfg_ch.data[DEPTH_W-1:0];
          REG_QDIV:  cf_qdiv = cfg_ch.data[QDIV_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.has_point)
          place_depth(depth_of(in_ch.point_x, in_ch.point_y, in_ch.point_z));
        if (in_ch.last_slot) begin
          want = typed_now ? typed_res : frame_quantile();
          quant_expq.insert(quant_expq.size(), want);
          depth_sorted.delete();
          frame_ovf = 1'b0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (quant_expq.size() == 0) begin
          bad_count++;
          $display("%0t unexpected result: depth %0d no_points %0b overflowed %0b", $time,
                   out_ch.depth_quantile, out_ch.no_points, out_ch.overflowed);
        end else begin
          want = quant_expq.pop_front();
          if (out_ch.depth_quantile !== want.depth) begin
            bad_count++;
            $display("%0t depth_quantile mismatch: expected %0d, actual %0d", $time,
                     want.depth, out_ch.depth_quantile);
          end
          if (out_ch.no_points !== want.none) begin
            bad_count++;
            $display("%0t no_points mismatch: expected %0b, actual %0b", $time,
                     want.none, out_ch.no_points);
          end
          if (out_ch.overflowed !== want.ovf) begin
            bad_count++;
            $display("%0t overflowed mismatch: expected %0b, actual %0b", $time,
                     want.ovf, out_ch.overflowed);
          end
        end
      end
    end
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic put_slot(slot_t s, logic typed, quant_res_t tr);
    typed_now = typed;
    typed_res = tr;
    in_ch.valid     <= 1'b1;
    in_ch.has_point <= s.has;
    in_ch.point_x   <= s.x;
    in_ch.point_y   <= s.y;
    in_ch.point_z   <= s.z;
    in_ch.last_slot <= s.last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_items++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (quant_expq.size() != 0);
  endtask

  task automatic set_pose(coef_t rx, coef_t ry, coef_t rz, depth_t tz,
                          logic [QDIV_W-1:0] qd, logic [4:0] sel);
    logic [CFG_DATA_W-1:0] vals [5];
    vals[REG_ROT_X] = CFG_DATA_W'(rx);
    vals[REG_ROT_Y] = CFG_DATA_W'(ry);
    vals[REG_ROT_Z] = CFG_DATA_W'(rz);
    vals[REG_TRANS] = tz;
    vals[REG_QDIV]  = CFG_DATA_W'(qd);
    for (int i = REG_ROT_X; i <= REG_QDIV; i++) begin
      if (sel[i]) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IDX_W'(i);
        cfg_ch.data  <= vals[i];
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(int n, int dens);
    slot_t      s;
    quant_res_t nil;
    nil = '{32'sd0, 1'b0, 1'b0};
    for (int i = 0; i < n; i++) begin
      s.has  = ($urandom_range(99) < dens);
      s.x    = rand_coord();
      s.y    = rand_coord();
      s.z    = rand_coord();
      s.last = (i == n - 1);
      put_slot(s, 1'b0, nil);
    end
  endtask

  task automatic run_frames(int n_items);
    int goal;
    int r;
    int len;
    int dens;
    int frames;
    goal   = sent_items + n_items;
    frames = 0;
    while (sent_items < goal) begin
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(1, 8) :
            (r < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
      dens = ($urandom_range(19) == 0) ? 0 : $urandom_range(60, 100);
      send_frame(len, dens);
      frames++;
      if (frames == 1 || $urandom_range(9) == 0) wait_drained();
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.has_point = 1'b0;
    in_ch.point_x   = '0;
    in_ch.point_y   = '0;
    in_ch.point_z   = '0;
    in_ch.last_slot = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_ROT_X;
    cfg_ch.data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gap_pct = 25;
    for (int i = 0; i < N_DIR; i++)
      put_slot(dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      repeat (16) @(negedge clk);
      case (p)
        0: set_pose(rand_coef(), rand_coef(), rand_coef(), rand_coord(),
                    QDIV_W'($urandom_range(1, 4)), 5'b11111);
        1: set_pose(18'sd65536, 18'sd65536, 18'sd65536, DEPTH_MAX, 8'd1, 5'b11111);
        2: set_pose(-18'sd65536, -18'sd65536, -18'sd65536, DEPTH_MIN, 8'd255, 5'b11111);
        3: set_pose(rand_coef(), rand_coef(), rand_coef(), rand_coord(), 8'd0, 5'b11111);
        default: set_pose(rand_coef(), rand_coef(), rand_coef(), rand_coord(),
                          QDIV_W'($urandom_range(1) ? $urandom_range(1, 4)
                                                    : $urandom_range(255)),
                          5'($urandom_range(1, 31)));
      endcase
      gap_pct = (p == 2 || p == 7) ? 0 : 30;
      if (p == 4)
        send_frame(MAX_POINTS + $urandom_range(1, 6), 100);
      else
        run_frames(50);
    end

    wait_drained();
    repeat (32) @(negedge clk);
    if (bad_count == 0 && quant_expq.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
